/* design/lvq_pkg.sv */
// Shared types, constants and functions for the Las Vegas queen placer.
`default_nettype none
package lvq_pkg;

	localparam int ROW_W   = 4;   // row and column field width
	localparam int CNT_W   = 5;   // board size, row count, candidate count
	localparam int WORD_W  = 32;  // xorshift word
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
	localparam int FIELD_MAX = 16; // limit set by the 4-bit row and column fields

	// modulo unit: bits of the random word consumed per cycle
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = WORD_W / MOD_BITS;
	localparam int MOD_CW    = $clog2(MOD_STEPS);

	localparam logic [CNT_W-1:0] BOARD_SIZE_RST = 5'd8;

	// register index, taken from paddr[2]
	localparam logic REG_BOARD_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_MOD,
		ST_PLACE,
		ST_EMIT_OK,
		ST_EMIT_FAIL
	} lvq_state_t;

	typedef struct packed {
		logic start;      // load seed, clear board
		logic scan;       // test one column, append to candidate list
		logic mod_init;   // advance random word, clear remainder
		logic mod_step;   // one step of word mod candidate count
		logic place;      // commit chosen queen, go to next row
		logic emit_ok;    // load next success result
		logic emit_fail;  // load the failure result
	} lvq_cmd_t;

	typedef struct packed {
		logic col_last;
		logic cand_none;
		logic mod_last;
		logic row_last;
		logic emit_last;
		logic out_free;
	} lvq_status_t;

	function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] x;
		x = w;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage
`default_nettype wire

/* design/lvq_ctrl.sv */
// Controller state machine of the queen placer.
`default_nettype none
module lvq_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  seed_valid,
	output logic                 seed_stall,
	input  lvq_pkg::lvq_status_t status,
	output lvq_pkg::lvq_cmd_t    cmd
);

	lvq_pkg::lvq_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lvq_pkg::ST_IDLE: begin
				if (seed_valid) state_d = lvq_pkg::ST_SCAN;
			end
			lvq_pkg::ST_SCAN: begin
				if (status.col_last) state_d = lvq_pkg::ST_CHECK;
			end
			lvq_pkg::ST_CHECK: begin
				state_d = status.cand_none ? lvq_pkg::ST_EMIT_FAIL : lvq_pkg::ST_MOD;
			end
			lvq_pkg::ST_MOD: begin
				if (status.mod_last) state_d = lvq_pkg::ST_PLACE;
			end
			lvq_pkg::ST_PLACE: begin
				state_d = status.row_last ? lvq_pkg::ST_EMIT_OK : lvq_pkg::ST_SCAN;
			end
			lvq_pkg::ST_EMIT_OK: begin
				if (status.out_free && status.emit_last) state_d = lvq_pkg::ST_IDLE;
			end
			lvq_pkg::ST_EMIT_FAIL: begin
				if (status.out_free) state_d = lvq_pkg::ST_IDLE;
			end
			default: state_d = lvq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		seed_stall = 1'b1;
		unique case (state_q)
			lvq_pkg::ST_IDLE: begin
				seed_stall = 1'b0;
				cmd.start  = seed_valid;
			end
			lvq_pkg::ST_SCAN:      cmd.scan      = 1'b1;
			lvq_pkg::ST_CHECK:     cmd.mod_init  = !status.cand_none;
			lvq_pkg::ST_MOD:       cmd.mod_step  = 1'b1;
			lvq_pkg::ST_PLACE:     cmd.place     = 1'b1;
			lvq_pkg::ST_EMIT_OK:   cmd.emit_ok   = status.out_free;
			lvq_pkg::ST_EMIT_FAIL: cmd.emit_fail = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* design/lvq_datapath.sv */
// Datapath of the queen placer: attack masks, candidate list, modulo unit, result register.
`default_nettype none
module lvq_datapath #(
	parameter int MAX_BOARD = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [lvq_pkg::CNT_W-1:0]         board_size,
	input  wire  [lvq_pkg::WORD_W-1:0]        seed,
	input  lvq_pkg::lvq_cmd_t                 cmd,
	output lvq_pkg::lvq_status_t              status,
	output logic                              result_valid,
	input  wire                               result_stall,
	output logic [lvq_pkg::ROW_W-1:0]         row,
	output logic [lvq_pkg::ROW_W-1:0]         column,
	output logic                              solved,
	output logic [lvq_pkg::CNT_W-1:0]         rows_placed,
	output logic                              last
);

	localparam int EFF_MAX = (MAX_BOARD < lvq_pkg::FIELD_MAX) ? MAX_BOARD : lvq_pkg::FIELD_MAX;
	localparam int IDX_W   = $clog2(EFF_MAX);
	localparam int CW      = lvq_pkg::CNT_W;

	// board state
	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 row_q;
	logic [IDX_W-1:0]              col_q;
	logic [CW-1:0]                 cnt_q;
	logic [EFF_MAX-1:0]            cols_q, ldiag_q, rdiag_q;
	logic [IDX_W-1:0]              cand_mem [EFF_MAX];
	logic [IDX_W-1:0]              queen_mem [EFF_MAX];

	// modulo unit
	logic [lvq_pkg::WORD_W-1:0]    word_q;
	logic [lvq_pkg::WORD_W-1:0]    mod_sh_q;
	logic [CW-1:0]                 rem_q;
	logic [lvq_pkg::MOD_CW-1:0]    mod_cnt_q;

	// result side
	logic [CW-1:0]                 emit_row_q;
	logic                          out_valid_q;

	logic [CW-1:0]                 n_eff;
	logic [EFF_MAX-1:0]            free_cols;
	logic [IDX_W-1:0]              pick;
	logic [EFF_MAX-1:0]            pick_bit;
	logic [CW-1:0]                 rem_d;
	logic [lvq_pkg::WORD_W-1:0]    word_next;

	always_comb begin
		if (board_size == '0) begin
			n_eff = CW'(1);
		end else if (board_size > CW'(EFF_MAX)) begin
			n_eff = CW'(EFF_MAX);
		end else begin
			n_eff = board_size;
		end
	end

	assign free_cols = ~(cols_q | ldiag_q | rdiag_q);
	assign pick      = cand_mem[rem_q[IDX_W-1:0]];
	assign pick_bit  = EFF_MAX'(1) << pick;
	assign word_next = lvq_pkg::next_word(word_q);

	// restoring remainder, MOD_BITS bits of the word per cycle
	always_comb begin
		logic [CW-1:0] t;
		rem_d = rem_q;
		for (int i = 0; i < lvq_pkg::MOD_BITS; i++) begin
			t = {rem_d[CW-2:0], mod_sh_q[lvq_pkg::WORD_W-1-i]};
			if (t >= cnt_q) t = t - cnt_q;
			rem_d = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			mod_cnt_q   <= '0;
			emit_row_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				n_q        <= n_eff;
				row_q      <= '0;
				col_q      <= '0;
				cnt_q      <= '0;
				emit_row_q <= '0;
			end
			if (cmd.scan) begin
				col_q <= col_q + 1'b1;
				if (free_cols[col_q]) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mod_init) begin
				mod_cnt_q <= '0;
			end
			if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (cmd.place) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.emit_ok) begin
				emit_row_q <= emit_row_q + 1'b1;
			end
			if (cmd.emit_ok || cmd.emit_fail) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			word_q  <= seed;
			cols_q  <= '0;
			ldiag_q <= '0;
			rdiag_q <= '0;
		end
		if (cmd.scan && free_cols[col_q]) begin
			cand_mem[cnt_q[IDX_W-1:0]] <= col_q;
		end
		if (cmd.mod_init) begin
			word_q   <= word_next;
			mod_sh_q <= word_next;
			rem_q    <= '0;
		end
		if (cmd.mod_step) begin
			rem_q    <= rem_d;
			mod_sh_q <= mod_sh_q << lvq_pkg::MOD_BITS;
		end
		if (cmd.place) begin
			queen_mem[row_q[IDX_W-1:0]] <= pick;
			cols_q  <= cols_q | pick_bit;
			ldiag_q <= (ldiag_q | pick_bit) << 1;
			rdiag_q <= (rdiag_q | pick_bit) >> 1;
		end
		if (cmd.emit_ok) begin
			row         <= emit_row_q[lvq_pkg::ROW_W-1:0];
			column      <= lvq_pkg::ROW_W'(queen_mem[emit_row_q[IDX_W-1:0]]);
			solved      <= 1'b1;
			rows_placed <= n_q;
			last        <= (emit_row_q + 1'b1) == n_q;
		end
		if (cmd.emit_fail) begin
			row         <= '0;
			column      <= '0;
			solved      <= 1'b0;
			rows_placed <= row_q;
			last        <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;

	assign status.col_last  = (CW'(col_q) + 1'b1) == n_q;
	assign status.cand_none = (cnt_q == '0);
	assign status.mod_last  = (mod_cnt_q == lvq_pkg::MOD_CW'(lvq_pkg::MOD_STEPS - 1));
	assign status.row_last  = (row_q + 1'b1) == n_q;
	assign status.emit_last = (emit_row_q + 1'b1) == n_q;
	assign status.out_free  = !out_valid_q || !result_stall;

	a_place_has_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> (cnt_q != '0) && (rem_q < cnt_q))
		else $error("queen placed from an empty or overrun candidate list");

	a_row_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= n_q)
		else $error("row counter ran past the board");

	a_scan_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> CW'(col_q) < n_q)
		else $error("column scan ran past the board");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ok || cmd.emit_fail) |-> (!out_valid_q || !result_stall))
		else $error("result register reloaded while a transfer is pending");

endmodule
`default_nettype wire

/* design/las_vegas_queen_placer.sv */
// Top level of the Las Vegas n-queens placer: configuration port, controller, datapath.
//
// Usage:
//   seed channel (seed_valid / seed_stall / seed): each transfer starts one randomized
//   attempt to place one queen per row on an n-by-n board, n from board_size.
//   result channel (result_valid / result_stall / row, column, solved, rows_placed,
//   last): a success gives n transfers, rows 0..n-1 in order, the final one with
//   last set; a failure gives a single transfer with solved = 0, rows_placed = rows
//   filled, last = 1.
//   APB port: register 0 (byte address 0) is board_size, 5 bits, reset 8. A size of 0
//   acts as 1, sizes above min(MAX_BOARD, 16) are clamped. Write it only while idle.
// Sequence:
//   Per row the datapath scans n columns one per cycle, then checks for a candidate,
//   reduces the word modulo the candidate count (4 bits a cycle) and places the
//   queen. One attempt runs at a time; seed_stall is low only between attempts.
// Reset: arst_n clears the controller, counters and result valid; board_size goes to 8.
// Stall: the result register holds its transfer while result_stall is high; the next
//   attempt may be accepted while the final result of the previous one still waits.
`default_nettype none
module las_vegas_queen_placer #(
	parameter int MAX_BOARD = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [lvq_pkg::APB_AW-1:0]       paddr,
	input  wire  [lvq_pkg::APB_DW-1:0]       pwdata,
	output logic [lvq_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	// seed channel
	input  wire                              seed_valid,
	output logic                             seed_stall,
	input  wire  [lvq_pkg::WORD_W-1:0]       seed,
	// result channel
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic [lvq_pkg::ROW_W-1:0]        row,
	output logic [lvq_pkg::ROW_W-1:0]        column,
	output logic                             solved,
	output logic [lvq_pkg::CNT_W-1:0]        rows_placed,
	output logic                             last
);

	logic [lvq_pkg::CNT_W-1:0] board_size_q;
	logic                      cfg_write;
	lvq_pkg::lvq_cmd_t         cmd;
	lvq_pkg::lvq_status_t      status;

	// APB: zero-wait writes; only the register slot (paddr[2]) is decoded
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= lvq_pkg::BOARD_SIZE_RST;
		end else if (cfg_write && (paddr[2] == lvq_pkg::REG_BOARD_SIZE)) begin
			board_size_q <= pwdata[lvq_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == lvq_pkg::REG_BOARD_SIZE) begin
			prdata = lvq_pkg::APB_DW'(board_size_q);
		end
	end

	lvq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seed_valid),
		.seed_stall (seed_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lvq_datapath #(
		.MAX_BOARD (MAX_BOARD)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.board_size   (board_size_q),
		.seed         (seed),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row          (row),
		.column       (column),
		.solved       (solved),
		.rows_placed  (rows_placed),
		.last         (last)
	);

endmodule
`default_nettype wire

/* test/lvq_placement_checker.sv */
// Checker for the queen placer: tracks board size, predicts placements per seed, compares results.
module lvq_placement_checker #(
	parameter int MAX_BOARD = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [lvq_pkg::APB_AW-1:0]   paddr,
	input  wire  [lvq_pkg::APB_DW-1:0]   pwdata,
	input  wire                          pready,
	input  wire                          seed_valid,
	input  wire                          seed_stall,
	input  wire  [lvq_pkg::WORD_W-1:0]   seed,
	input  wire                          result_valid,
	input  wire                          result_stall,
	input  wire  [lvq_pkg::ROW_W-1:0]    row,
	input  wire  [lvq_pkg::ROW_W-1:0]    column,
	input  wire                          solved,
	input  wire  [lvq_pkg::CNT_W-1:0]    rows_placed,
	input  wire                          last,
	output int                           errors,
	output int                           pending
);

	typedef struct packed {
		logic [lvq_pkg::ROW_W-1:0] row;
		logic [lvq_pkg::ROW_W-1:0] column;
		logic                      solved;
		logic [lvq_pkg::CNT_W-1:0] rows_placed;
		logic                      last;
	} placement_t;

	placement_t                expected_placements[$];
	logic [lvq_pkg::CNT_W-1:0] board_size = lvq_pkg::BOARD_SIZE_RST;

	initial begin
		errors  = 0;
		pending = 0;
	end

	// one Las Vegas attempt: row by row, free columns ascending, xorshift pick
	function automatic void place_queens(input logic [lvq_pkg::WORD_W-1:0] start_word);
		logic [lvq_pkg::WORD_W-1:0] word;
		logic [lvq_pkg::ROW_W-1:0]  queens[16];
		logic [lvq_pkg::ROW_W-1:0]  free_cols[16];
		int                         n;
		int                         count;
		int                         qc;
		int                         gap;
		bit                         hit;
		placement_t                 p;
		word = start_word;
		n = board_size;
		if (n < 1) n = 1;
		if (n > MAX_BOARD) n = MAX_BOARD;
		if (n > lvq_pkg::FIELD_MAX) n = lvq_pkg::FIELD_MAX;
		for (int r = 0; r < n; r++) begin
			count = 0;
			for (int c = 0; c < n; c++) begin
				hit = 0;
				for (int j = 0; j < r; j++) begin
					qc = queens[j];
					gap = (qc > c) ? qc - c : c - qc;
					if (qc == c || gap == r - j) hit = 1;
				end
				if (!hit) begin
					free_cols[count] = c[lvq_pkg::ROW_W-1:0];
					count++;
				end
			end
			if (count == 0) begin
				p.row         = '0;
				p.column      = '0;
				p.solved      = 1'b0;
				p.rows_placed = r[lvq_pkg::CNT_W-1:0];
				p.last        = 1'b1;
				expected_placements.push_back(p);
				return;
			end
			word = word ^ (word << 13);
			word = word ^ (word >> 17);
			word = word ^ (word << 5);
			queens[r] = free_cols[word % count];
		end
		for (int r = 0; r < n; r++) begin
			p.row         = r[lvq_pkg::ROW_W-1:0];
			p.column      = queens[r];
			p.solved      = 1'b1;
			p.rows_placed = n[lvq_pkg::CNT_W-1:0];
			p.last        = (r == n - 1);
			expected_placements.push_back(p);
		end
	endfunction

	task automatic note_mismatch(input bit orphan, input placement_t want,
		input placement_t got);
		errors++;
		if (errors <= 10) begin
			if (orphan) begin
				$display("unexpected result: row %0d col %0d solved %0d placed %0d last %0d",
					got.row, got.column, got.solved, got.rows_placed, got.last);
			end else begin
				$display("result mismatch: exp row %0d col %0d solved %0d placed %0d last %0d",
					want.row, want.column, want.solved, want.rows_placed, want.last);
				$display("                 got row %0d col %0d solved %0d placed %0d last %0d",
					got.row, got.column, got.solved, got.rows_placed, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		placement_t got;
		placement_t want;
		if (!arst_n) begin
			board_size = lvq_pkg::BOARD_SIZE_RST;
			expected_placements.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == lvq_pkg::REG_BOARD_SIZE)
				board_size = pwdata[lvq_pkg::CNT_W-1:0];
			if (result_valid && !result_stall) begin
				got = {row, column, solved, rows_placed, last};
				if (expected_placements.size() == 0) begin
					note_mismatch(1'b1, got, got);
				end else begin
					want = expected_placements.pop_front();
					if (got !== want) note_mismatch(1'b0, want, got);
				end
			end
			if (seed_valid && !seed_stall) place_queens(seed);
			pending = expected_placements.size();
		end
	end

endmodule

/* test/tb_las_vegas_queen_placer.sv */
// Testbench top for the queen placer: clock, reset, seed and config stimulus, verdict.
module tb_las_vegas_queen_placer;

	localparam int MAX_BOARD   = 16;
	localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either channel
	localparam int TAIL_CYCLES = 450;   // idle cycles after the final drain, before the verdict
	localparam logic [lvq_pkg::APB_AW-1:0] ADDR_BOARD_SIZE = {lvq_pkg::REG_BOARD_SIZE, 2'b00};
	localparam logic [lvq_pkg::APB_AW-1:0] ADDR_SPARE      = {~lvq_pkg::REG_BOARD_SIZE, 2'b00};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [lvq_pkg::APB_AW-1:0]  paddr;
	logic [lvq_pkg::APB_DW-1:0]  pwdata;
	logic [lvq_pkg::APB_DW-1:0]  prdata;
	logic                        pready;
	logic                        seed_valid;
	logic                        seed_stall;
	logic [lvq_pkg::WORD_W-1:0]  seed;
	logic                        result_valid;
	logic                        result_stall;
	logic [lvq_pkg::ROW_W-1:0]   row;
	logic [lvq_pkg::ROW_W-1:0]   column;
	logic                        solved;
	logic [lvq_pkg::CNT_W-1:0]   rows_placed;
	logic                        last;
	int                          errors;
	int                          pending;
	int                          send_idle;    // percent of cycles the seed side holds back
	int                          recv_idle;    // percent of cycles the result side stalls
	int                          quiet_cycles = 0;

	las_vegas_queen_placer #(.MAX_BOARD(MAX_BOARD)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.seed_valid   (seed_valid),
		.seed_stall   (seed_stall),
		.seed         (seed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row          (row),
		.column       (column),
		.solved       (solved),
		.rows_placed  (rows_placed),
		.last         (last)
	);

	lvq_placement_checker #(.MAX_BOARD(MAX_BOARD)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.seed_valid   (seed_valid),
		.seed_stall   (seed_stall),
		.seed         (seed),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row          (row),
		.column       (column),
		.solved       (solved),
		.rows_placed  (rows_placed),
		.last         (last),
		.errors       (errors),
		.pending      (pending)
	);

	always #10 clk = ~clk;

	// result side: random stall, updated on the falling edge only
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// watchdog: an attempt on a 16x16 board with a slow receiver stays well under the limit
	always @(posedge clk) begin
		if (arst_n) begin
			if ((seed_valid && !seed_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("las_vegas_queen_placer verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one seed transfer; random hold-off first, payload steady until accepted
	task automatic send_seed(input logic [lvq_pkg::WORD_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle) begin
			seed_valid <= 1'b0;
			@(negedge clk);
		end
		seed_valid <= 1'b1;
		seed       <= value;
		do @(posedge clk); while (seed_stall !== 1'b0);
		@(negedge clk);
	endtask

	// hold the seed side until every predicted result has been taken
	task automatic drain();
		seed_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// APB write: setup phase, then access phase until pready
	task automatic apb_write(input logic [lvq_pkg::APB_AW-1:0] addr,
		input logic [lvq_pkg::APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// board size change while idle; upper data bits are random noise
	task automatic set_board(input logic [lvq_pkg::CNT_W-1:0] size);
		logic [lvq_pkg::APB_DW-1:0] data;
		drain();
		data = $urandom;
		data[lvq_pkg::CNT_W-1:0] = size;
		apb_write(ADDR_BOARD_SIZE, data);
	endtask

	initial begin
		int                        chunk;
		logic [lvq_pkg::CNT_W-1:0] size;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		seed_valid   = 1'b0;
		seed         = '0;
		result_stall = 1'b0;
		send_idle    = 31;
		recv_idle    = 84;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset board size 8: zero seed (always first free column) and seed bit extremes
		send_seed(32'h0000_0000);
		send_seed(32'h0000_0001);
		send_seed(32'hFFFF_FFFF);
		send_seed(32'h8000_0000);
		send_seed(32'h5555_5555);
		send_seed(32'hAAAA_AAAA);
		// size zero acts as a 1x1 board
		set_board(5'd0);
		send_seed(32'h0000_0000);
		send_seed($urandom);
		set_board(5'd1);
		send_seed($urandom);
		// 2x2 and 3x3 never solve: failure after some rows
		set_board(5'd2);
		send_seed($urandom);
		set_board(5'd3);
		send_seed($urandom);
		set_board(5'd4);
		repeat (3) send_seed($urandom);
		set_board(5'd16);
		send_seed($urandom);
		send_seed(32'h0000_0000);
		// oversize values clamp to the largest board
		set_board(5'd31);
		send_seed($urandom);
		set_board(5'd17);
		send_seed($urandom);
		// write to the unused address must leave the board size alone
		drain();
		apb_write(ADDR_SPARE, 32'd5);
		send_seed($urandom);

		// random seeds in chunks, each chunk on its own board size
		for (chunk = 0; chunk < 10; chunk++) begin
			if (chunk == 4) begin
				send_idle = 84;
				recv_idle = 31;
			end
			if (chunk == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(0, 3) == 0)
				size = lvq_pkg::CNT_W'($urandom_range(0, 31));
			else
				size = lvq_pkg::CNT_W'($urandom_range(4, 10));
			set_board(size);
			repeat (18) send_seed($urandom);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("las_vegas_queen_placer verification clean");
		else
			$display("las_vegas_queen_placer verification failed");
		$finish;
	end

endmodule
